// ===== hdl/ush_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ush_pkg: shared types and constants of the solar hijri time converter
// epoch offset, reciprocal multipliers for the constant divisions, calendar
// constants and the item types handed between the pipeline sections
// ----------------------------------------------------------------------------
package ush_pkg;

  localparam logic [31:0] EPOCH_OFFSET = 32'd6813000;

  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam int DAY_PER_WEEK = 7;
  localparam int DAY_PER_YEAR = 365;
  localparam int CYCLE_YEARS  = 33;
  localparam int LEAP_OFS_A   = 12;
  localparam int LEAP_OFS_B   = 13;
  localparam int BASE_YEAR    = 1349;

  localparam int SUMMER_LAST_DAY  = 186;
  localparam int EARLY_MONTH_DAYS = 31;
  localparam int LATE_MONTH_DAYS  = 30;
  localparam int FIRST_LATE_MONTH = 6;
  localparam int MONTHS_PER_YEAR  = 12;
  localparam int LAST_HOUR        = 23;

  // floor(2^k / d): estimate is exact or one low, fixed by one compare
  localparam logic [31:0] RECIP_60_A = 32'd1145324612;  // 2^36 / 60
  localparam logic [31:0] RECIP_60_B = 32'd71582788;    // 2^32 / 60
  localparam logic [31:0] RECIP_24   = 32'd2796202;     // 2^26 / 24
  localparam logic [31:0] RECIP_365  = 32'd45964;       // 2^24 / 365
  localparam logic [31:0] RECIP_7    = 32'd74898;       // 2^19 / 7

  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_SUMMER = 1'b0;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [15:0] days;
  } ush_clk_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [2:0] dow;
    logic [7:0] ycnt;
    logic [8:0] yday;
    logic       leap;
  } ush_date_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [2:0]  dow;
    logic [10:0] year;
    logic [8:0]  yday;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic        leap;
  } ush_res_t;

endpackage
`default_nettype wire

// ===== hdl/ush_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ush_clock: seconds count to time of day and day count
// seven stages: clamp, then multiply and correct for /60, /60 and /24
// ----------------------------------------------------------------------------
module ush_clock (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  wire              in_valid,
  input  wire  [31:0]      in_seconds,
  output logic             out_valid,
  output ush_pkg::ush_clk_t out_item
);

  logic [6:0]  vld_r;

  logic [31:0] t_r, t_nxt;
  logic [26:0] q1e_r, q1_r, q1_nxt;
  logic [6:0]  lo1_r, lo2_r;
  logic [20:0] q2e_r, q2_r, q2_nxt;
  logic [5:0]  lo3_r;
  logic [15:0] q3e_r, days_r, days_nxt;
  logic [5:0]  sec2_r, sec3_r, sec4_r, sec5_r, sec6_r, sec_nxt;
  logic [5:0]  min4_r, min5_r, min6_r, min_nxt;
  logic [4:0]  hr_r, hr_nxt;

  logic [63:0] p1, p2, p3;
  logic [6:0]  r1, r2;
  logic [5:0]  r3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_comb begin
    t_nxt = (in_seconds < ush_pkg::EPOCH_OFFSET) ? '0 : in_seconds - ush_pkg::EPOCH_OFFSET;
    p1 = 64'(t_r) * 64'(ush_pkg::RECIP_60_A);

    r1 = lo1_r - 7'(q1e_r[6:0] * 7'(ush_pkg::SEC_PER_MIN));
    if (r1 >= 7'(ush_pkg::SEC_PER_MIN)) begin
      sec_nxt = 6'(r1 - 7'(ush_pkg::SEC_PER_MIN));
      q1_nxt  = q1e_r + 27'd1;
    end else begin
      sec_nxt = r1[5:0];
      q1_nxt  = q1e_r;
    end

    p2 = 64'(q1_r) * 64'(ush_pkg::RECIP_60_B);

    r2 = lo2_r - 7'(q2e_r[6:0] * 7'(ush_pkg::MIN_PER_HOUR));
    if (r2 >= 7'(ush_pkg::MIN_PER_HOUR)) begin
      min_nxt = 6'(r2 - 7'(ush_pkg::MIN_PER_HOUR));
      q2_nxt  = q2e_r + 21'd1;
    end else begin
      min_nxt = r2[5:0];
      q2_nxt  = q2e_r;
    end

    p3 = 64'(q2_r) * 64'(ush_pkg::RECIP_24);

    r3 = lo3_r - 6'(q3e_r[5:0] * 6'(ush_pkg::HOUR_PER_DAY));
    if (r3 >= 6'(ush_pkg::HOUR_PER_DAY)) begin
      hr_nxt   = 5'(r3 - 6'(ush_pkg::HOUR_PER_DAY));
      days_nxt = q3e_r + 16'd1;
    end else begin
      hr_nxt   = r3[4:0];
      days_nxt = q3e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      q1e_r  <= p1[62:36];
      lo1_r  <= t_r[6:0];
      q1_r   <= q1_nxt;
      sec2_r <= sec_nxt;
      q2e_r  <= p2[52:32];
      lo2_r  <= q1_r[6:0];
      sec3_r <= sec2_r;
      q2_r   <= q2_nxt;
      min4_r <= min_nxt;
      sec4_r <= sec3_r;
      q3e_r  <= p3[41:26];
      lo3_r  <= q2_r[5:0];
      min5_r <= min4_r;
      sec5_r <= sec4_r;
      days_r <= days_nxt;
      hr_r   <= hr_nxt;
      min6_r <= min5_r;
      sec6_r <= sec5_r;
    end
  end

  assign out_valid     = vld_r[6];
  assign out_item.sec  = sec6_r;
  assign out_item.min  = min6_r;
  assign out_item.hr   = hr_r;
  assign out_item.days = days_r;

endmodule
`default_nettype wire

// ===== hdl/ush_date.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ush_date: day count to weekday, elapsed years, day of year and leap flag
// six stages: /365 and /7 estimates, correction, leap terms, day offset,
// second /365 estimate and its correction
// ----------------------------------------------------------------------------
module ush_date (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire               in_valid,
  input  wire  ush_pkg::ush_clk_t in_item,
  output logic              out_valid,
  output ush_pkg::ush_date_t out_item
);

  logic [5:0]  vld_r;

  ush_pkg::ush_clk_t s1_r, s2_r, s3_r;
  logic [7:0]  tye_r, ty_r, ty_nxt;
  logic [3:0]  de7_r;
  logic [2:0]  dow2_r, dow3_r, dow4_r, dow5_r, dow6_r, dow_nxt;
  logic [5:0]  tl_r, tl_nxt;
  logic        leap3_r, leap4_r, leap5_r, leap6_r, leap_nxt;
  logic [15:0] e_r, e_nxt;
  logic [5:0]  sec4_r, sec5_r, sec6_r;
  logic [5:0]  min4_r, min5_r, min6_r;
  logic [4:0]  hr4_r, hr5_r, hr6_r;
  logic [7:0]  ye_r, ycnt_r, ycnt_nxt;
  logic [9:0]  elo_r;
  logic [8:0]  yday_r, yday_nxt;

  logic [63:0] pa, pb, pe;
  logic [9:0]  ra, re;
  logic [3:0]  r7;
  logic [8:0]  sa, sb;
  logic [2:0]  qa, qb;
  logic [7:0]  da, db;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_comb begin
    pa = 64'(in_item.days) * 64'(ush_pkg::RECIP_365);
    pb = 64'(in_item.days) * 64'(ush_pkg::RECIP_7);

    ra = s1_r.days[9:0] - 10'(10'(tye_r) * 10'(ush_pkg::DAY_PER_YEAR));
    ty_nxt = (ra >= 10'(ush_pkg::DAY_PER_YEAR)) ? tye_r + 8'd1 : tye_r;
    r7 = s1_r.days[3:0] - 4'(de7_r * 4'(ush_pkg::DAY_PER_WEEK));
    dow_nxt = (r7 >= 4'(ush_pkg::DAY_PER_WEEK)) ?
              3'(r7 - 4'(ush_pkg::DAY_PER_WEEK)) : r7[2:0];

    // 33-year cycle terms, the quotient is at most four
    sa = 9'(ty_r) + 9'(ush_pkg::LEAP_OFS_A);
    sb = 9'(ty_r) + 9'(ush_pkg::LEAP_OFS_B);
    qa = '0;
    qb = '0;
    for (int j = 1; j <= 4; j++) begin
      if (sa >= 9'(ush_pkg::CYCLE_YEARS * j)) qa = qa + 3'd1;
      if (sb >= 9'(ush_pkg::CYCLE_YEARS * j)) qb = qb + 3'd1;
    end
    da = ty_r - 8'(qa);
    db = ty_r - 8'(qb);
    tl_nxt   = da[7:2];
    leap_nxt = (db[1:0] == 2'b11);

    e_nxt = s3_r.days - 16'(tl_r);

    pe = 64'(e_r) * 64'(ush_pkg::RECIP_365);

    re = elo_r - 10'(10'(ye_r) * 10'(ush_pkg::DAY_PER_YEAR));
    if (re >= 10'(ush_pkg::DAY_PER_YEAR)) begin
      yday_nxt = 9'(re - 10'(ush_pkg::DAY_PER_YEAR));
      ycnt_nxt = ye_r + 8'd1;
    end else begin
      yday_nxt = re[8:0];
      ycnt_nxt = ye_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= in_item;
      tye_r   <= pa[31:24];
      de7_r   <= pb[22:19];
      s2_r    <= s1_r;
      ty_r    <= ty_nxt;
      dow2_r  <= dow_nxt;
      s3_r    <= s2_r;
      dow3_r  <= dow2_r;
      tl_r    <= tl_nxt;
      leap3_r <= leap_nxt;
      e_r     <= e_nxt;
      dow4_r  <= dow3_r;
      leap4_r <= leap3_r;
      sec4_r  <= s3_r.sec;
      min4_r  <= s3_r.min;
      hr4_r   <= s3_r.hr;
      ye_r    <= pe[31:24];
      elo_r   <= e_r[9:0];
      dow5_r  <= dow4_r;
      leap5_r <= leap4_r;
      sec5_r  <= sec4_r;
      min5_r  <= min4_r;
      hr5_r   <= hr4_r;
      yday_r  <= yday_nxt;
      ycnt_r  <= ycnt_nxt;
      dow6_r  <= dow5_r;
      leap6_r <= leap5_r;
      sec6_r  <= sec5_r;
      min6_r  <= min5_r;
      hr6_r   <= hr5_r;
    end
  end

  assign out_valid     = vld_r[5];
  assign out_item.sec  = sec6_r;
  assign out_item.min  = min6_r;
  assign out_item.hr   = hr6_r;
  assign out_item.dow  = dow6_r;
  assign out_item.ycnt = ycnt_r;
  assign out_item.yday = yday_r;
  assign out_item.leap = leap6_r;

endmodule
`default_nettype wire

// ===== hdl/ush_month.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ush_month: summer hour shift, year number, month and day of month
// two stages: hour adjustment and year offset, then month split
// ----------------------------------------------------------------------------
module ush_month (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                summer_en,
  input  wire                in_valid,
  input  wire  ush_pkg::ush_date_t in_item,
  output logic               out_valid,
  output ush_pkg::ush_res_t  out_item
);

  logic [1:0]  vld_r;

  ush_pkg::ush_date_t m1_r;
  logic [10:0] year1_r, year_nxt;
  logic        late_r, late_nxt;
  logic [4:0]  hr1_r, hr_nxt;
  logic [8:0]  yday1_r, yday_nxt;
  ush_pkg::ush_res_t res_r, res_nxt;

  logic [7:0]  lo;
  logic [2:0]  k;
  logic [2:0]  m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_comb begin
    year_nxt = 11'(ush_pkg::BASE_YEAR) + 11'(in_item.ycnt);
    late_nxt = (in_item.yday > 9'(ush_pkg::SUMMER_LAST_DAY));
    hr_nxt   = in_item.hr;
    yday_nxt = in_item.yday;
    if (!late_nxt && summer_en) begin
      if (in_item.hr == 5'(ush_pkg::LAST_HOUR)) begin
        hr_nxt   = '0;
        yday_nxt = in_item.yday + 9'd1;
      end else begin
        hr_nxt = in_item.hr + 5'd1;
      end
    end

    lo = 8'(yday1_r - 9'(ush_pkg::SUMMER_LAST_DAY));
    k  = '0;
    for (int j = 1; j < ush_pkg::MONTHS_PER_YEAR - ush_pkg::FIRST_LATE_MONTH; j++) begin
      if (lo >= 8'(ush_pkg::LATE_MONTH_DAYS * j)) k = k + 3'd1;
    end
    m = '0;
    for (int j = 1; j <= ush_pkg::FIRST_LATE_MONTH; j++) begin
      if (yday1_r >= 9'(ush_pkg::EARLY_MONTH_DAYS * j)) m = m + 3'd1;
    end

    res_nxt.sec  = m1_r.sec;
    res_nxt.min  = m1_r.min;
    res_nxt.hr   = hr1_r;
    res_nxt.dow  = m1_r.dow;
    res_nxt.year = year1_r;
    res_nxt.yday = yday1_r;
    res_nxt.leap = m1_r.leap;
    if (late_r) begin
      res_nxt.mon  = 4'(ush_pkg::FIRST_LATE_MONTH) + 4'(k);
      res_nxt.mday = 5'(lo - 8'(8'(k) * 8'(ush_pkg::LATE_MONTH_DAYS)));
    end else begin
      res_nxt.mon  = 4'(m);
      res_nxt.mday = 5'(yday1_r - 9'(9'(m) * 9'(ush_pkg::EARLY_MONTH_DAYS)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= in_item;
      year1_r <= year_nxt;
      late_r  <= late_nxt;
      hr1_r   <= hr_nxt;
      yday1_r <= yday_nxt;
      res_r   <= res_nxt;
    end
  end

  assign out_valid = vld_r[1];
  assign out_item  = res_r;

endmodule
`default_nettype wire

// ===== hdl/unix_time_to_solar_hijri_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unix_time_to_solar_hijri_core: unix seconds to solar hijri broken-down time
// pipelined converter with stream input and output and an apb register port
// ----------------------------------------------------------------------------
// Accepts one transaction per clock cycle while in_tready is high and delivers
// one result per input. Each result passes through 7 stages that split off
// seconds, minutes, hours and days, 6 stages that derive weekday, year and
// day of year, 2 stages that apply the summer hour and split the month, then
// the output register. A two-entry output buffer holds results while
// out_tready is low; the whole pipeline stops only once its second entry is
// in use. Inputs below 6813000 are treated as 6813000. Register 0 at byte
// address 0, bit 0, enables the summer hour for the first 187 days of the
// year; write it only while idle.
// ----------------------------------------------------------------------------
module unix_time_to_solar_hijri_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,    // unix_seconds
  output logic        out_tvalid,
  input  wire         out_tready,
  // second_of_minute, minute_of_hour, hour_of_day, weekday_index,
  // calendar_year, year_day, month_index, month_day, leap_flag, zero pad
  output logic [55:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [ush_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic summer_r;
  logic cfg_wr;

  logic en;
  logic clk_valid, date_valid, res_valid;
  ush_pkg::ush_clk_t  clk_item;
  ush_pkg::ush_date_t date_item;
  ush_pkg::ush_res_t  res_item;

  ush_pkg::ush_res_t out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic push;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == ush_pkg::CFG_IDX_SUMMER) ? 32'(summer_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summer_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == ush_pkg::CFG_IDX_SUMMER) begin
      summer_r <= cfg_pwdata[0];
    end
  end

  assign en        = !skid_v_r;
  assign in_tready = en;

  ush_clock u_clock (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .in_seconds (in_tdata),
    .out_valid  (clk_valid),
    .out_item   (clk_item)
  );

  ush_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (clk_valid),
    .in_item   (clk_item),
    .out_valid (date_valid),
    .out_item  (date_item)
  );

  ush_month u_month (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .summer_en (summer_r),
    .in_valid  (date_valid),
    .in_item   (date_item),
    .out_valid (res_valid),
    .out_item  (res_item)
  );

  assign push = res_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res_item;
      end
    end else if (push) begin
      skid_r <= res_item;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_r.leap, out_r.mday, out_r.mon, out_r.yday, out_r.year,
                       out_r.dow, out_r.hr, out_r.min, out_r.sec};

  // buffer entry only in use behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("output buffer holds a result while the output register is empty");

  // a result pushed into a stalled output must land in the buffer
  a_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_v_r && !out_tready) |=> skid_v_r)
    else $error("result pushed into a stalled output was dropped");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.hr <= 5'd23 && out_r.min <= 6'd59 && out_r.sec <= 6'd59))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.mon <= 4'd11 && out_r.mday <= 5'd30 && out_r.yday <= 9'd365
                 && out_r.dow <= 3'd6))
    else $error("date field out of range");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: unix seconds to solar hijri converter
// A table of directed timestamps runs first: the clamp below the epoch, the
// top of the 32-bit range, year, leap and month boundaries, and the summer
// hour with its wrap at hour 23. Random timestamps follow in phases that
// change the summer setting, sender gaps and receiver stalls. One phase holds
// the output back long enough to stall the input. Every result is checked
// field by field against a table date or an in-bench calendar predictor.
// ----------------------------------------------------------------------------
module testbench;
  import ush_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 80;
  localparam int LAST_DAY = 49630;
  localparam logic [CFG_ADDR_W-1:0] SUMMER_ADDR = CFG_ADDR_W'(4 * CFG_IDX_SUMMER);

  typedef struct {
    bit          summer;
    logic [31:0] secs;
    bit          known;
    ush_res_t    date;
  } probe_t;

  typedef struct {
    int idle;
    int stall;
    bit summer;
    bit hold;
    int count;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ush_res_t pending_dates[$];
  probe_t   probe_rows[$];
  ush_res_t want_date;
  ush_res_t got_date;
  bit       summer_on = 1'b0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_kicks = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       mismatches = 0;
  int       cycle_count = 0;

  phase_t phases[6] = '{
    '{0, 0, 1'b0, 1'b0, 100},
    '{61, 0, 1'b1, 1'b0, 100},
    '{0, 61, 1'b0, 1'b0, 100},
    '{7, 7, 1'b1, 1'b0, 100},
    '{0, 0, 1'b0, 1'b1, 100},
    '{0, 0, 1'b1, 1'b0, 50}
  };

  unix_time_to_solar_hijri_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic ush_res_t solar_date_of(input logic [31:0] secs, input bit summer);
    longint unsigned t, hr, days, ty, tl, e, yday, mon;
    ush_res_t r;
    t = (secs < EPOCH_OFFSET) ? 0 : longint'(secs - EPOCH_OFFSET);
    r.sec = 6'(t % SEC_PER_MIN);
    t = t / SEC_PER_MIN;
    r.min = 6'(t % MIN_PER_HOUR);
    t = t / MIN_PER_HOUR;
    hr = t % HOUR_PER_DAY;
    days = t / HOUR_PER_DAY;
    r.dow = 3'(days % DAY_PER_WEEK);
    ty = days / DAY_PER_YEAR;
    tl = (ty - (ty + LEAP_OFS_A) / CYCLE_YEARS) / 4;
    e = days - tl;
    yday = e % DAY_PER_YEAR;
    r.year = 11'(BASE_YEAR + e / DAY_PER_YEAR);
    r.leap = ((ty - (ty + LEAP_OFS_B) / CYCLE_YEARS) % 4) == 3;
    if (yday > SUMMER_LAST_DAY) begin
      mon = FIRST_LATE_MONTH + (yday - SUMMER_LAST_DAY) / LATE_MONTH_DAYS;
      r.mday = 5'(yday - (FIRST_LATE_MONTH + mon * LATE_MONTH_DAYS));
    end else begin
      // summer hour, wrapping into the next day of year but not the weekday
      if (summer) begin
        if (hr == LAST_HOUR) begin
          hr = 0;
          yday++;
        end else begin
          hr++;
        end
      end
      mon = yday / EARLY_MONTH_DAYS;
      r.mday = 5'(yday - mon * EARLY_MONTH_DAYS);
    end
    r.hr = 5'(hr);
    r.yday = 9'(yday);
    r.mon = 4'(mon);
    return r;
  endfunction

  function automatic logic [31:0] stamp(input int days, input int h, input int m, input int s);
    return 32'(longint'(EPOCH_OFFSET) + longint'(days) * 86400 + h * 3600 + m * 60 + s);
  endfunction

  function automatic ush_res_t date_of(input int sec, input int min, input int hr,
                                       input int dow, input int year, input int yday,
                                       input int mon, input int mday, input int leap);
    ush_res_t r;
    r.sec = 6'(sec);
    r.min = 6'(min);
    r.hr = 5'(hr);
    r.dow = 3'(dow);
    r.year = 11'(year);
    r.yday = 9'(yday);
    r.mon = 4'(mon);
    r.mday = 5'(mday);
    r.leap = 1'(leap);
    return r;
  endfunction

  function automatic logic [31:0] random_seconds();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return $urandom();
      1: return $urandom_range(EPOCH_OFFSET - 1, 0);
      2, 3: return stamp($urandom_range(LAST_DAY), LAST_HOUR, $urandom_range(59),
                         $urandom_range(59));
      // days around the end of the summer months of a random year
      4, 5: return stamp($urandom_range(134) * DAY_PER_YEAR + $urandom_range(192, 180),
                         $urandom_range(23), $urandom_range(59), $urandom_range(59));
      default: return stamp($urandom_range(LAST_DAY), $urandom_range(23),
                            $urandom_range(59), $urandom_range(59));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic offer_seconds(input logic [31:0] secs, input bit known,
                               input ush_res_t date);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= secs;
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(known ? date : solar_date_of(secs, summer_on));
    @(negedge clk);
  endtask

  task automatic wait_dates_drained();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_summer(input bit on);
    logic [31:0] word;
    word = $urandom();
    word[0] = on;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= SUMMER_ADDR;
    cfg_pwdata <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    summer_on = on;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // receiver: long hold-off on request, otherwise random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_kicks != hold_seen) begin
        hold_seen = hold_kicks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dates.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_tdata);
        mismatches++;
      end else begin
        want_date = pending_dates.pop_front();
        got_date.sec = out_tdata[5:0];
        got_date.min = out_tdata[11:6];
        got_date.hr = out_tdata[16:12];
        got_date.dow = out_tdata[19:17];
        got_date.year = out_tdata[30:20];
        got_date.yday = out_tdata[39:31];
        got_date.mon = out_tdata[43:40];
        got_date.mday = out_tdata[48:44];
        got_date.leap = out_tdata[49];
        check_field("second_of_minute", want_date.sec, got_date.sec);
        check_field("minute_of_hour", want_date.min, got_date.min);
        check_field("hour_of_day", want_date.hr, got_date.hr);
        check_field("weekday_index", want_date.dow, got_date.dow);
        check_field("calendar_year", want_date.year, got_date.year);
        check_field("year_day", want_date.yday, got_date.yday);
        check_field("month_index", want_date.mon, got_date.mon);
        check_field("month_day", want_date.mday, got_date.mday);
        check_field("leap_flag", want_date.leap, got_date.leap);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    probe_rows.push_back('{1'b0, 32'd0, 1'b1, date_of(0, 0, 0, 0, 1349, 0, 0, 0, 0)});
    probe_rows.push_back('{1'b0, EPOCH_OFFSET - 1, 1'b1,
                           date_of(0, 0, 0, 0, 1349, 0, 0, 0, 0)});
    probe_rows.push_back('{1'b0, EPOCH_OFFSET, 1'b1, date_of(0, 0, 0, 0, 1349, 0, 0, 0, 0)});
    probe_rows.push_back('{1'b0, 32'hFFFF_FFFF, 1'b1,
                           date_of(15, 58, 9, 1, 1484, 324, 10, 18, 1)});
    probe_rows.push_back('{1'b0, stamp(0, 23, 59, 59), 1'b1,
                           date_of(59, 59, 23, 0, 1349, 0, 0, 0, 0)});
    probe_rows.push_back('{1'b0, stamp(186, 12, 0, 0), 1'b0, '0});
    probe_rows.push_back('{1'b0, stamp(187, 0, 0, 0), 1'b0, '0});
    probe_rows.push_back('{1'b0, stamp(364, 23, 59, 59), 1'b0, '0});
    probe_rows.push_back('{1'b0, stamp(365, 0, 0, 0), 1'b0, '0});
    probe_rows.push_back('{1'b0, stamp(1459, 5, 6, 7), 1'b0, '0});
    probe_rows.push_back('{1'b0, stamp(1460, 0, 0, 0), 1'b0, '0});
    probe_rows.push_back('{1'b0, 32'h8000_0000, 1'b0, '0});
    probe_rows.push_back('{1'b0, 32'h5555_5555, 1'b0, '0});
    probe_rows.push_back('{1'b0, 32'hAAAA_AAAA, 1'b0, '0});
    probe_rows.push_back('{1'b1, 32'd0, 1'b1, date_of(0, 0, 1, 0, 1349, 0, 0, 0, 0)});
    probe_rows.push_back('{1'b1, stamp(0, 23, 0, 0), 1'b1,
                           date_of(0, 0, 0, 0, 1349, 1, 0, 1, 0)});
    probe_rows.push_back('{1'b1, stamp(186, 22, 30, 0), 1'b0, '0});
    probe_rows.push_back('{1'b1, stamp(186, 23, 59, 59), 1'b0, '0});
    probe_rows.push_back('{1'b1, stamp(187, 23, 0, 0), 1'b0, '0});
    probe_rows.push_back('{1'b1, stamp(30, 23, 0, 0), 1'b0, '0});
    probe_rows.push_back('{1'b1, 32'hFFFF_FFFF, 1'b1,
                           date_of(15, 58, 9, 1, 1484, 324, 10, 18, 1)});
    probe_rows.push_back('{1'b1, stamp(1459, 23, 0, 0), 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_summer(1'b0);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].summer != summer_on) begin
        wait_dates_drained();
        write_summer(probe_rows[i].summer);
      end
      offer_seconds(probe_rows[i].secs, probe_rows[i].known, probe_rows[i].date);
    end

    foreach (phases[p]) begin
      wait_dates_drained();
      write_summer(phases[p].summer);
      idle_pct = phases[p].idle;
      stall_pct = phases[p].stall;
      if (phases[p].hold) hold_kicks++;
      repeat (phases[p].count) offer_seconds(random_seconds(), 1'b0, '0);
    end

    wait_dates_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
